// File: rtl/core/variable_step_ab3_coefficients_macros.svh
// Assertion macros used by the checker file of the weight generator.
`ifndef VARIABLE_STEP_AB3_COEFFICIENTS_MACROS_SVH
`define VARIABLE_STEP_AB3_COEFFICIENTS_MACROS_SVH

// Implication checked in the same cycle, off while reset is high.
`define VSAB3_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vsab3 checker: implication failed");

// Implication checked in the next cycle, off while reset is high.
`define VSAB3_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vsab3 checker: next-cycle implication failed");

// Condition that must hold in the cycle after reset was high.
`define VSAB3_ASSERT_AFTER_RESET(label, cons) \
   label: assert property (@(posedge clock) $past(reset) |-> (cons)) \
      else $error("vsab3 checker: post-reset condition failed");

`endif

// File: rtl/core/vsab3_pkg.sv
// Shared types and constants of the variable-step AB3 weight generator.
package vsab3_pkg;

   localparam int PORT_TIME_BITS = 40;
   localparam int TIME_EXT_BITS = 48;
   localparam int STEP_BITS = 32;
   localparam int WEIGHT_BITS = 32;
   localparam int STATUS_BITS = 2;

   // Multiplier digit width and quotient bits produced by the divider chain.
   localparam int CHUNK_BITS = 8;
   localparam int QUOT_BITS = 33;
   localparam int DIV_LATENCY = QUOT_BITS + 2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_ZERO_DIV = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_SATURATED = 2'd2;

   localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
   localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

   typedef struct packed {
      logic neg;
      logic sat;
   } vsab3_flags_type;

endpackage

// File: rtl/core/vsab3_req_if.sv
// Request channel: four time points and a step width.
interface vsab3_req_if import vsab3_pkg::*;;
   logic valid;
   logic ready;
   logic [PORT_TIME_BITS-1:0] time_oldest;
   logic [PORT_TIME_BITS-1:0] time_older;
   logic [PORT_TIME_BITS-1:0] time_now;
   logic [PORT_TIME_BITS-1:0] time_next;
   logic [STEP_BITS-1:0] step_width;

   modport source (output valid, time_oldest, time_older, time_now, time_next, step_width,
                   input ready);
   modport sink (input valid, time_oldest, time_older, time_now, time_next, step_width,
                 output ready);
endinterface

// File: rtl/core/vsab3_rsp_if.sv
// Response channel: three weights and a status code.
interface vsab3_rsp_if import vsab3_pkg::*;;
   logic valid;
   logic ready;
   logic signed [WEIGHT_BITS-1:0] weight_now;
   logic signed [WEIGHT_BITS-1:0] weight_older;
   logic signed [WEIGHT_BITS-1:0] weight_oldest;
   logic [STATUS_BITS-1:0] status;

   modport source (output valid, weight_now, weight_older, weight_oldest, status,
                   input ready);
   modport sink (input valid, weight_now, weight_older, weight_oldest, status,
                 output ready);
endinterface

// File: rtl/core/vsab3_mul.sv
// Pipelined signed multiplier: a row of cells, each adding one digit of the multiplier.
module vsab3_mul import vsab3_pkg::*; #(
   parameter int A_W = 16,
   parameter int B_W = 16
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [A_W-1:0]       mul_a,
   input  logic signed [B_W-1:0]       mul_b,
   output logic signed [A_W+B_W-1:0]   product_ff
);
   localparam int PW = A_W + B_W;
   localparam int NCH = (B_W + CHUNK_BITS - 1) / CHUNK_BITS;
   localparam int BP = NCH * CHUNK_BITS;

   logic [A_W-1:0] a_abs;
   logic [B_W-1:0] b_abs;
   logic [A_W-1:0] ma_ff [NCH];
   logic [BP-1:0]  mb_ff [NCH];
   logic [PW-1:0]  acc_ff [NCH+1];
   logic           sg_ff [NCH+1];

   assign a_abs = mul_a[A_W-1] ? -mul_a : mul_a;
   assign b_abs = mul_b[B_W-1] ? -mul_b : mul_b;

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff[0] <= a_abs;
         mb_ff[0] <= BP'(b_abs);
         acc_ff[0] <= '0;
         sg_ff[0] <= mul_a[A_W-1] ^ mul_b[B_W-1];
      end
   end

   for (genvar k = 0; k < NCH; k++) begin : g_cell
      logic [A_W+CHUNK_BITS-1:0] pp;
      assign pp = ma_ff[k] * mb_ff[k][CHUNK_BITS-1:0];

      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[k+1] <= acc_ff[k] + (PW'(pp) << (k * CHUNK_BITS));
            sg_ff[k+1] <= sg_ff[k];
         end
      end

      if (k < NCH - 1) begin : g_pass
         always_ff @(posedge clock) begin
            if (en) begin
               ma_ff[k+1] <= ma_ff[k];
               mb_ff[k+1] <= mb_ff[k] >> CHUNK_BITS;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         product_ff <= sg_ff[NCH] ? -$signed(acc_ff[NCH]) : $signed(acc_ff[NCH]);
      end
   end

endmodule

// File: rtl/core/vsab3_div_cell.sv
// One restoring-division cell: decides one quotient bit and passes the remainder on.
module vsab3_div_cell import vsab3_pkg::*; #(
   parameter int RW = 64,
   parameter int DW = 32,
   parameter int SHIFT = 0
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [RW-1:0]          prev_rem,
   input  logic [DW-1:0]          prev_den,
   input  logic [QUOT_BITS-1:0]   prev_quot,
   input  vsab3_flags_type        prev_flags,
   output logic [RW-1:0]          rem_ff,
   output logic [DW-1:0]          den_ff,
   output logic [QUOT_BITS-1:0]   quot_ff,
   output vsab3_flags_type        flags_ff
);
   logic [RW-1:0] den_shift;
   logic          take;
   logic [RW-1:0] rem_in;
   logic [QUOT_BITS-1:0] quot_in;

   always_comb begin
      den_shift = RW'(prev_den) << SHIFT;
      take = prev_rem >= den_shift;
      rem_in = take ? prev_rem - den_shift : prev_rem;
      quot_in = prev_quot;
      quot_in[SHIFT] = take;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         den_ff <= prev_den;
         quot_ff <= quot_in;
         flags_ff <= prev_flags;
      end
   end

endmodule

// File: rtl/core/vsab3_div.sv
// Signed fixed-point divider: overflow check, a chain of quotient cells, rounding.
module vsab3_div import vsab3_pkg::*; #(
   parameter int NW = 64,
   parameter int DW = 64,
   parameter int FRAC_BITS = 28
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [NW-1:0]          num,
   input  logic signed [DW-1:0]          den,
   output logic signed [WEIGHT_BITS-1:0] weight_ff,
   output logic                          sat_ff
);
   localparam int RA = NW + FRAC_BITS + 1;
   localparam int RB = DW + QUOT_BITS + 1;
   localparam int RW = (RA > RB) ? RA : RB;
   localparam logic [QUOT_BITS-1:0] POS_LIMIT = QUOT_BITS'(64'h7FFF_FFFF);
   localparam logic [QUOT_BITS-1:0] NEG_LIMIT = QUOT_BITS'(64'h8000_0000);

   logic [NW-1:0] num_mag;
   logic [DW-1:0] den_mag;
   logic [RW-1:0] rem_start;
   vsab3_flags_type flags_in;

   logic [RW-1:0]        rem_pre_ff;
   logic [DW-1:0]        den_pre_ff;
   vsab3_flags_type      flags_pre_ff;

   logic [RW-1:0]        rem_link [QUOT_BITS+1];
   logic [DW-1:0]        den_link [QUOT_BITS+1];
   logic [QUOT_BITS-1:0] quot_link [QUOT_BITS+1];
   vsab3_flags_type      flags_link [QUOT_BITS+1];

   assign num_mag = num[NW-1] ? -num : num;
   assign den_mag = den[DW-1] ? -den : den;
   assign rem_start = RW'(num_mag) << (FRAC_BITS + 1);

   // A quotient of 2^33 or more cannot round into 32 bits.
   always_comb begin
      flags_in.neg = num[NW-1] ^ den[DW-1];
      flags_in.sat = rem_start >= (RW'(den_mag) << QUOT_BITS);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_pre_ff <= rem_start;
         den_pre_ff <= den_mag;
         flags_pre_ff <= flags_in;
      end
   end

   assign rem_link[0] = rem_pre_ff;
   assign den_link[0] = den_pre_ff;
   assign quot_link[0] = '0;
   assign flags_link[0] = flags_pre_ff;

   for (genvar i = 0; i < QUOT_BITS; i++) begin : g_cell
      vsab3_div_cell #(
         .RW(RW),
         .DW(DW),
         .SHIFT(QUOT_BITS - 1 - i)
      ) u_cell (
         .clock(clock),
         .en(en),
         .prev_rem(rem_link[i]),
         .prev_den(den_link[i]),
         .prev_quot(quot_link[i]),
         .prev_flags(flags_link[i]),
         .rem_ff(rem_link[i+1]),
         .den_ff(den_link[i+1]),
         .quot_ff(quot_link[i+1]),
         .flags_ff(flags_link[i+1])
      );
   end

   logic [QUOT_BITS:0]        quot_plus;
   logic [QUOT_BITS-1:0]      mag;
   logic [WEIGHT_BITS-1:0]    mag_w;
   logic                      over;
   vsab3_flags_type           fl;
   logic signed [WEIGHT_BITS-1:0] weight_in;
   logic                      sat_in;

   // The quotient carries one extra fraction bit; adding one and halving rounds
   // to nearest with ties away from zero.
   always_comb begin
      fl = flags_link[QUOT_BITS];
      quot_plus = {1'b0, quot_link[QUOT_BITS]} + (QUOT_BITS+1)'(1);
      mag = quot_plus[QUOT_BITS:1];
      mag_w = mag[WEIGHT_BITS-1:0];
      over = fl.neg ? (mag > NEG_LIMIT) : (mag > POS_LIMIT);
      sat_in = fl.sat | over;
      if (sat_in) begin
         weight_in = fl.neg ? WEIGHT_MIN : WEIGHT_MAX;
      end else begin
         weight_in = fl.neg ? $signed(-mag_w) : $signed(mag_w);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         weight_ff <= weight_in;
         sat_ff <= sat_in;
      end
   end

endmodule

// File: rtl/core/variable_step_ab3_coefficients.sv
// Variable-step third-order Adams-Bashforth weight generator, top level.
//
// req_chan carries four time points (oldest, older, now, next) and a step
// width; rsp_chan returns weight_now, weight_older and weight_oldest in
// signed fixed point with FRAC_BITS fraction bits, plus a status code
// (ok, zero divisor, saturated). Every request yields exactly one response.
// The datapath is a fully pipelined chain: time differences, two rows of
// digit-serial multiplier cells (ceil((TIME_BITS+2)/8)+2 and
// ceil(max(TIME_BITS+4, STEP_BITS+1)/8)+2 stages), then two 33-cell
// restoring dividers (35 stages), one quotient bit per cell.
// Throughput is one transaction per cycle while the skid register is empty.
// Reset clears the pipeline valid bits and the output and skid valid flags.
// When the receiver stalls, one more finished response parks in a skid
// register; req_chan.ready drops only while that register is full, and the
// whole pipeline then holds until the response register drains.
module variable_step_ab3_coefficients import vsab3_pkg::*; #(
   parameter int TIME_BITS = 40,
   parameter int FRAC_BITS = 28
) (
   input logic          clock,
   input logic          reset,
   vsab3_req_if.sink    req_chan,
   vsab3_rsp_if.source  rsp_chan
);
   localparam int TW = TIME_BITS + 1;
   localparam int AW1 = TW + 1;
   localparam int PW1 = 2 * AW1;
   localparam int L1 = (AW1 + CHUNK_BITS - 1) / CHUNK_BITS + 2;
   localparam int CW = TW + 3;
   localparam int AW2 = 2 * TW + 4;
   localparam int BW2 = (CW > STEP_BITS + 1) ? CW : STEP_BITS + 1;
   localparam int PW2 = AW2 + BW2;
   localparam int L2 = (BW2 + CHUNK_BITS - 1) / CHUNK_BITS + 2;
   localparam int QW = PW2 + 3;
   localparam int LAT = L1 + L2 + 3 + DIV_LATENCY;
   localparam int DLW = TW + STEP_BITS + CW;
   localparam int OSW = WEIGHT_BITS + 2;

   logic en;
   logic accept;

   // Input stage: time differences and divisor check.
   logic [TIME_EXT_BITS-1:0] ext_oldest, ext_older, ext_now, ext_next;
   logic [TIME_BITS-1:0]     t_oldest, t_older, t_now, t_next;
   logic signed [TW-1:0]     a_in, b_in, h_in;
   logic                     err_in;

   assign ext_oldest = TIME_EXT_BITS'(req_chan.time_oldest);
   assign ext_older = TIME_EXT_BITS'(req_chan.time_older);
   assign ext_now = TIME_EXT_BITS'(req_chan.time_now);
   assign ext_next = TIME_EXT_BITS'(req_chan.time_next);
   assign t_oldest = ext_oldest[TIME_BITS-1:0];
   assign t_older = ext_older[TIME_BITS-1:0];
   assign t_now = ext_now[TIME_BITS-1:0];
   assign t_next = ext_next[TIME_BITS-1:0];

   assign a_in = $signed({1'b0, t_now}) - $signed({1'b0, t_older});
   assign b_in = $signed({1'b0, t_now}) - $signed({1'b0, t_oldest});
   assign h_in = $signed({1'b0, t_next}) - $signed({1'b0, t_now});
   assign err_in = (t_now == t_older) || (t_now == t_oldest) || (t_older == t_oldest) ||
                   (req_chan.step_width == '0);

   logic skid_valid_ff;
   assign en = !skid_valid_ff;
   assign accept = req_chan.valid && en;
   assign req_chan.ready = en;

   logic signed [TW-1:0] a1_ff, b1_ff, h1_ff;
   logic [STEP_BITS-1:0] s1_ff;
   logic                 v_ff [LAT];
   logic                 e_ff [LAT];

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff <= a_in;
         b1_ff <= b_in;
         h1_ff <= h_in;
         s1_ff <= req_chan.step_width;
         e_ff[0] <= err_in;
         for (int i = 1; i < LAT; i++) begin
            e_ff[i] <= e_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= accept;
         for (int i = 1; i < LAT; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // First multiplier row: ab, h(a+b), h^2, a(b-a).
   logic signed [AW1-1:0] a_w, b_w, h_w, sab_w, bma_w;
   logic signed [CW-1:0]  c3b2h;
   logic signed [PW1-1:0] p_ab, p_hs, p_hh, p_abma;

   assign a_w = AW1'(a1_ff);
   assign b_w = AW1'(b1_ff);
   assign h_w = AW1'(h1_ff);
   assign sab_w = a_w + b_w;
   assign bma_w = b_w - a_w;
   assign c3b2h = (CW'(b1_ff) <<< 1) + CW'(b1_ff) + (CW'(h1_ff) <<< 1);

   vsab3_mul #(.A_W(AW1), .B_W(AW1)) u_mul_ab (
      .clock(clock), .en(en), .mul_a(a_w), .mul_b(b_w), .product_ff(p_ab));
   vsab3_mul #(.A_W(AW1), .B_W(AW1)) u_mul_hs (
      .clock(clock), .en(en), .mul_a(h_w), .mul_b(sab_w), .product_ff(p_hs));
   vsab3_mul #(.A_W(AW1), .B_W(AW1)) u_mul_hh (
      .clock(clock), .en(en), .mul_a(h_w), .mul_b(h_w), .product_ff(p_hh));
   vsab3_mul #(.A_W(AW1), .B_W(AW1)) u_mul_abma (
      .clock(clock), .en(en), .mul_a(a_w), .mul_b(bma_w), .product_ff(p_abma));

   // h, s and 3b+2h ride alongside the first row.
   logic [DLW-1:0] dly_ff [L1];

   always_ff @(posedge clock) begin
      if (en) begin
         dly_ff[0] <= {h1_ff, s1_ff, c3b2h};
         for (int i = 1; i < L1; i++) begin
            dly_ff[i] <= dly_ff[i-1];
         end
      end
   end

   // Second stage: the weight_now numerator polynomial 6ab + 3h(a+b) + 2h^2.
   logic signed [AW2-1:0] p1_x, p2_x, p3_x, n0_in;
   logic signed [AW2-1:0] n0_ff, p1_ff, q1_ff, p3_ff;
   logic signed [TW-1:0]  h2_ff;
   logic [STEP_BITS-1:0]  s2_ff;
   logic signed [CW-1:0]  c2_ff;

   assign p1_x = AW2'(p_ab);
   assign p2_x = AW2'(p_hs);
   assign p3_x = AW2'(p_hh);
   assign n0_in = (p1_x <<< 2) + (p1_x <<< 1) + (p2_x <<< 1) + p2_x + (p3_x <<< 1);

   always_ff @(posedge clock) begin
      if (en) begin
         n0_ff <= n0_in;
         p1_ff <= p1_x;
         q1_ff <= AW2'(p_abma);
         p3_ff <= p3_x;
         {h2_ff, s2_ff, c2_ff} <= dly_ff[L1-1];
      end
   end

   // Second multiplier row.
   logic signed [BW2-1:0] h2_w, s2_w, c2_w;
   logic signed [PW2-1:0] m_num0, m_den0, m_den1, m_num1;

   assign h2_w = BW2'(h2_ff);
   assign s2_w = BW2'($signed({1'b0, s2_ff}));
   assign c2_w = BW2'(c2_ff);

   vsab3_mul #(.A_W(AW2), .B_W(BW2)) u_mul_num0 (
      .clock(clock), .en(en), .mul_a(n0_ff), .mul_b(h2_w), .product_ff(m_num0));
   vsab3_mul #(.A_W(AW2), .B_W(BW2)) u_mul_den0 (
      .clock(clock), .en(en), .mul_a(p1_ff), .mul_b(s2_w), .product_ff(m_den0));
   vsab3_mul #(.A_W(AW2), .B_W(BW2)) u_mul_den1 (
      .clock(clock), .en(en), .mul_a(q1_ff), .mul_b(s2_w), .product_ff(m_den1));
   vsab3_mul #(.A_W(AW2), .B_W(BW2)) u_mul_num1 (
      .clock(clock), .en(en), .mul_a(p3_ff), .mul_b(c2_w), .product_ff(m_num1));

   // Third stage: scale denominators by six and negate the older numerator.
   logic signed [QW-1:0] d0_x, d1_x;
   logic signed [QW-1:0] num0_ff, den0_ff, num1_ff, den1_ff;

   assign d0_x = QW'(m_den0);
   assign d1_x = QW'(m_den1);

   always_ff @(posedge clock) begin
      if (en) begin
         num0_ff <= QW'(m_num0);
         den0_ff <= (d0_x <<< 2) + (d0_x <<< 1);
         num1_ff <= -QW'(m_num1);
         den1_ff <= (d1_x <<< 2) + (d1_x <<< 1);
      end
   end

   logic signed [WEIGHT_BITS-1:0] w_now, w_older;
   logic                          sat_now, sat_older;

   vsab3_div #(.NW(QW), .DW(QW), .FRAC_BITS(FRAC_BITS)) u_div_now (
      .clock(clock), .en(en), .num(num0_ff), .den(den0_ff),
      .weight_ff(w_now), .sat_ff(sat_now));
   vsab3_div #(.NW(QW), .DW(QW), .FRAC_BITS(FRAC_BITS)) u_div_older (
      .clock(clock), .en(en), .num(num1_ff), .den(den1_ff),
      .weight_ff(w_older), .sat_ff(sat_older));

   // Result assembly: the oldest weight closes the sum to one.
   logic signed [OSW-1:0]         old_sum;
   logic signed [WEIGHT_BITS-1:0] res_now, res_older, res_oldest;
   logic [STATUS_BITS-1:0]        res_status;
   logic                          sat_oldest;

   always_comb begin
      old_sum = (OSW'(1) <<< FRAC_BITS) - OSW'(w_now) - OSW'(w_older);
      sat_oldest = 1'b0;
      if (old_sum > OSW'(WEIGHT_MAX)) begin
         res_oldest = WEIGHT_MAX;
         sat_oldest = 1'b1;
      end else if (old_sum < OSW'(WEIGHT_MIN)) begin
         res_oldest = WEIGHT_MIN;
         sat_oldest = 1'b1;
      end else begin
         res_oldest = old_sum[WEIGHT_BITS-1:0];
      end
      res_now = w_now;
      res_older = w_older;
      res_status = (sat_now || sat_older || sat_oldest) ? STATUS_SATURATED : STATUS_OK;
      if (e_ff[LAT-1]) begin
         res_now = '0;
         res_older = '0;
         res_oldest = '0;
         res_status = STATUS_ZERO_DIV;
      end
   end

   // Output register with a skid register behind it.
   logic                          rsp_valid_ff;
   logic signed [WEIGHT_BITS-1:0] rsp_now_ff, rsp_older_ff, rsp_oldest_ff;
   logic [STATUS_BITS-1:0]        rsp_status_ff;
   logic signed [WEIGHT_BITS-1:0] skid_now_ff, skid_older_ff, skid_oldest_ff;
   logic [STATUS_BITS-1:0]        skid_status_ff;
   logic                          out_new;
   logic                          out_free;

   assign out_new = en && v_ff[LAT-1];
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (rsp_chan.ready) begin
               rsp_valid_ff <= 1'b1;
               skid_valid_ff <= 1'b0;
            end
         end else if (out_new) begin
            if (out_free) begin
               rsp_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_chan.ready) begin
            rsp_now_ff <= skid_now_ff;
            rsp_older_ff <= skid_older_ff;
            rsp_oldest_ff <= skid_oldest_ff;
            rsp_status_ff <= skid_status_ff;
         end
      end else if (out_new) begin
         if (out_free) begin
            rsp_now_ff <= res_now;
            rsp_older_ff <= res_older;
            rsp_oldest_ff <= res_oldest;
            rsp_status_ff <= res_status;
         end else begin
            skid_now_ff <= res_now;
            skid_older_ff <= res_older;
            skid_oldest_ff <= res_oldest;
            skid_status_ff <= res_status;
         end
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.weight_now = rsp_now_ff;
   assign rsp_chan.weight_older = rsp_older_ff;
   assign rsp_chan.weight_oldest = rsp_oldest_ff;
   assign rsp_chan.status = rsp_status_ff;

endmodule

// File: rtl/core/vsab3_checker.sv
// Port-level checks of the weight generator and their binding to the top level.
`include "variable_step_ab3_coefficients_macros.svh"

module vsab3_checker import vsab3_pkg::*; #(
   parameter int FRAC_BITS = 28
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [WEIGHT_BITS-1:0] weight_now,
   input logic signed [WEIGHT_BITS-1:0] weight_older,
   input logic signed [WEIGHT_BITS-1:0] weight_oldest,
   input logic [STATUS_BITS-1:0]        status
);
   localparam int SW = WEIGHT_BITS + 2;

   logic signed [SW-1:0] weight_sum;

   assign weight_sum = SW'(weight_now) + SW'(weight_older) + SW'(weight_oldest);

   // A stalled response keeps its payload.
   `VSAB3_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable({weight_now, weight_older, weight_oldest, status}))

   // Coincident times or a zero step give all-zero weights.
   `VSAB3_ASSERT_IMPLY(a_zero_div_weights, rsp_valid && (status == STATUS_ZERO_DIV), (weight_now == '0) && (weight_older == '0) && (weight_oldest == '0))

   // Unsaturated weights sum exactly to one.
   `VSAB3_ASSERT_IMPLY(a_weight_sum, rsp_valid && (status == STATUS_OK), weight_sum == (SW'(1) <<< FRAC_BITS))

   // Right after reset nothing is pending and requests are taken.
   `VSAB3_ASSERT_AFTER_RESET(a_reset_clear, !rsp_valid && req_ready)

endmodule

bind variable_step_ab3_coefficients vsab3_checker #(
   .FRAC_BITS(FRAC_BITS)
) u_vsab3_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .weight_now(rsp_chan.weight_now),
   .weight_older(rsp_chan.weight_older),
   .weight_oldest(rsp_chan.weight_oldest),
   .status(rsp_chan.status)
);

// File: verif/variable_step_ab3_coefficients_tb.sv
// Self-checking testbench of the variable-step third-order Adams-Bashforth weight generator.
module variable_step_ab3_coefficients_tb;
   import vsab3_pkg::*;

   localparam int FRAC = 28;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_ITEMS = 1030;

   typedef struct {
      logic [PORT_TIME_BITS-1:0] t_oldest;
      logic [PORT_TIME_BITS-1:0] t_older;
      logic [PORT_TIME_BITS-1:0] t_now;
      logic [PORT_TIME_BITS-1:0] t_next;
      logic [STEP_BITS-1:0] step;
   } time_set_type;

   typedef struct {
      logic signed [WEIGHT_BITS-1:0] w_now;
      logic signed [WEIGHT_BITS-1:0] w_older;
      logic signed [WEIGHT_BITS-1:0] w_oldest;
      logic [STATUS_BITS-1:0] status;
   } weight_set_type;

   typedef struct {
      time_set_type stim;
      bit typed;
      weight_set_type weights;
   } directed_row_type;

   localparam logic [PORT_TIME_BITS-1:0] T_MAX = {PORT_TIME_BITS{1'b1}};
   localparam logic signed [WEIGHT_BITS-1:0] ONE_Q = 32'sd1 <<< FRAC;

   logic clock;
   logic reset;
   vsab3_req_if req_chan ();
   vsab3_rsp_if rsp_chan ();

   variable_step_ab3_coefficients DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   weight_set_type pending_weights[$];
   int failures = 0;
   bit stimulus_done = 0;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Rounded, saturated quotient num/den in Q format; ties go away from zero.
   function automatic logic signed [63:0] quantize(logic signed [255:0] num,
                                                   logic signed [255:0] den,
                                                   inout bit sat);
      logic [255:0] rem;
      logic [255:0] dmag;
      logic [255:0] quo;
      logic [63:0] mag;
      bit neg;
      neg = num[255] ^ den[255];
      rem = num[255] ? -num : num;
      dmag = den[255] ? -den : den;
      rem = rem << (FRAC + 1);
      if (rem >= (dmag << 33)) begin
         sat = 1;
         return neg ? -64'sd2147483648 : 64'sd2147483647;
      end
      quo = rem / dmag;
      mag = (quo[63:0] + 64'd1) >> 1;
      if (!neg && mag > 64'd2147483647) begin
         sat = 1;
         return 64'sd2147483647;
      end
      if (neg && mag > 64'd2147483648) begin
         sat = 1;
         return -64'sd2147483648;
      end
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic weight_set_type ab3_weights(time_set_type t);
      weight_set_type w;
      logic signed [255:0] a, b, h, s, hh, num, den;
      logic signed [63:0] wn, wo, wold;
      bit sat;
      sat = 0;
      w.w_now = '0;
      w.w_older = '0;
      w.w_oldest = '0;
      w.status = STATUS_OK;
      if (t.t_now == t.t_older || t.t_now == t.t_oldest || t.t_older == t.t_oldest
          || t.step == 0) begin
         w.status = STATUS_ZERO_DIV;
         return w;
      end
      a = $signed({216'd0, t.t_now}) - $signed({216'd0, t.t_older});
      b = $signed({216'd0, t.t_now}) - $signed({216'd0, t.t_oldest});
      h = $signed({216'd0, t.t_next}) - $signed({216'd0, t.t_now});
      s = $signed({224'd0, t.step});
      hh = h * h;
      num = h * (6 * a * b + 3 * h * (a + b) + 2 * hh);
      den = 6 * a * b * s;
      wn = quantize(num, den, sat);
      num = -(hh * (3 * b + 2 * h));
      den = 6 * a * (b - a) * s;
      wo = quantize(num, den, sat);
      wold = (64'sd1 <<< FRAC) - wn - wo;
      if (wold > 64'sd2147483647) begin
         wold = 64'sd2147483647;
         sat = 1;
      end
      if (wold < -64'sd2147483648) begin
         wold = -64'sd2147483648;
         sat = 1;
      end
      w.w_now = wn[31:0];
      w.w_older = wo[31:0];
      w.w_oldest = wold[31:0];
      if (sat) w.status = STATUS_SATURATED;
      return w;
   endfunction

   function automatic logic [PORT_TIME_BITS-1:0] rand_time();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[PORT_TIME_BITS-1:0];
   endfunction

   // Mostly ascending time sets with step equal to next minus now; the rest are fully random sets or corner cases.
   function automatic time_set_type random_set();
      time_set_type t;
      logic [PORT_TIME_BITS-1:0] gap_mask;
      logic [PORT_TIME_BITS-1:0] span;
      int kind;
      kind = $urandom_range(0, 19);
      gap_mask = (40'd1 << $urandom_range(1, 37)) - 40'd1;
      t.t_oldest = rand_time();
      t.t_older = t.t_oldest + (rand_time() & gap_mask) + 40'd1;
      t.t_now = t.t_older + (rand_time() & gap_mask) + 40'd1;
      t.t_next = t.t_now + (rand_time() & gap_mask & 40'hFFFFFFFF);
      span = t.t_next - t.t_now;
      t.step = span[STEP_BITS-1:0];
      if (t.step == 0) t.step = 1;
      case (kind)
         0, 1: begin
            t.t_oldest = rand_time();
            t.t_older = rand_time();
            t.t_now = rand_time();
            t.t_next = rand_time();
            t.step = $urandom;
         end
         2: t.t_older = ($urandom_range(0, 1) != 0) ? t.t_now : t.t_oldest;
         3: t.step = ($urandom_range(0, 1) != 0) ? 32'd0 : $urandom;
         4: t.t_next = t.t_now - (rand_time() & gap_mask);
         5: t.t_next = t.t_now;
         default: ;
      endcase
      return t;
   endfunction

   directed_row_type directed_rows[] = '{
      '{'{40'd0, 40'd1, 40'd2, 40'd3, 32'd1}, 0, '{0, 0, 0, STATUS_OK}},
      '{'{40'd0, 40'd10, 40'd20, 40'd30, 32'd10}, 0, '{0, 0, 0, STATUS_OK}},
      '{'{40'd5, 40'd7, 40'd7, 40'd9, 32'd2}, 1, '{0, 0, 0, STATUS_ZERO_DIV}},
      '{'{40'd7, 40'd5, 40'd7, 40'd9, 32'd2}, 1, '{0, 0, 0, STATUS_ZERO_DIV}},
      '{'{40'd5, 40'd5, 40'd7, 40'd9, 32'd2}, 1, '{0, 0, 0, STATUS_ZERO_DIV}},
      '{'{40'd1, 40'd3, 40'd7, 40'd9, 32'd0}, 1, '{0, 0, 0, STATUS_ZERO_DIV}},
      '{'{T_MAX, T_MAX, T_MAX, T_MAX, 32'hFFFFFFFF}, 1, '{0, 0, 0, STATUS_ZERO_DIV}},
      '{'{40'd0, 40'd0, 40'd0, 40'd0, 32'd0}, 1, '{0, 0, 0, STATUS_ZERO_DIV}},
      '{'{40'd1, 40'd2, 40'd3, 40'd3, 32'd1}, 1, '{0, 0, ONE_Q, STATUS_OK}},
      '{'{40'd0, 40'd1, T_MAX, T_MAX, 32'hFFFFFFFF}, 1, '{0, 0, ONE_Q, STATUS_OK}},
      '{'{40'd0, 40'd1, 40'd2, T_MAX, 32'd1}, 0, '{0, 0, 0, STATUS_OK}},
      '{'{40'd0, 40'd1, 40'd2, 40'd3, 32'hFFFFFFFF}, 0, '{0, 0, 0, STATUS_OK}},
      '{'{T_MAX - 40'd2, T_MAX - 40'd1, T_MAX, 40'd0, 32'd1}, 0, '{0, 0, 0, STATUS_OK}},
      '{'{40'd30, 40'd20, 40'd10, 40'd0, 32'd10}, 0, '{0, 0, 0, STATUS_OK}},
      '{'{40'd0, T_MAX - 40'd1, T_MAX, 40'd0, 32'd1}, 0, '{0, 0, 0, STATUS_OK}},
      '{'{40'd0, 40'd1000, 40'd1001, 40'd1001 + 40'hFFFFFFFF, 32'hFFFFFFFF}, 0,
        '{0, 0, 0, STATUS_OK}},
      '{'{40'd0, 40'd100, 40'd200, 40'd203, 32'd3}, 0, '{0, 0, 0, STATUS_OK}},
      '{'{40'd3, 40'd5, 40'd9, 40'd10, 32'd1}, 0, '{0, 0, 0, STATUS_OK}},
      '{'{T_MAX, 40'd0, 40'd1, 40'd2, 32'd1}, 0, '{0, 0, 0, STATUS_OK}}
   };

   task automatic offer(time_set_type t, weight_set_type w);
      req_chan.valid <= 1'b1;
      req_chan.time_oldest <= t.t_oldest;
      req_chan.time_older <= t.t_older;
      req_chan.time_now <= t.t_now;
      req_chan.time_next <= t.t_next;
      req_chan.step_width <= t.step;
      do @(posedge clock); while (!req_chan.ready);
      pending_weights.push_back(w);
   endtask

   task automatic idle_sender(int cycles);
      req_chan.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Sender: directed table, then random bursts with gaps.
   initial begin
      time_set_type t;
      weight_set_type w;
      int burst;
      req_chan.valid = 1'b0;
      req_chan.time_oldest = '0;
      req_chan.time_older = '0;
      req_chan.time_now = '0;
      req_chan.time_next = '0;
      req_chan.step_width = '0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) begin
         if (directed_rows[i].typed) begin
            w = directed_rows[i].weights;
         end else begin
            w = ab3_weights(directed_rows[i].stim);
         end
         offer(directed_rows[i].stim, w);
         if ($urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 3));
      end
      for (int n = 0; n < RANDOM_ITEMS; ) begin
         burst = $urandom_range(1, 60);
         for (int k = 0; k < burst && n < RANDOM_ITEMS; k++, n++) begin
            t = random_set();
            offer(t, ab3_weights(t));
         end
         if (n >= 600 && n < 600 + burst) begin
            // Let the pipeline drain completely before going on.
            req_chan.valid <= 1'b0;
            do @(posedge clock); while (pending_weights.size() != 0);
         end else if ($urandom_range(0, 2) != 0) begin
            idle_sender($urandom_range(1, 12));
         end
      end
      req_chan.valid <= 1'b0;
      stimulus_done = 1;
   end

   // Receiver: stall patterns chosen at random, plus one long hold-off early in the run.
   initial begin
      int cyc;
      int mode;
      rsp_chan.ready = 1'b0;
      cyc = 0;
      mode = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc % 64 == 0) mode = $urandom_range(0, 3);
         if (cyc >= 300 && cyc < 600) rsp_chan.ready <= 1'b0;
         else case (mode)
            0: rsp_chan.ready <= 1'b1;
            1: rsp_chan.ready <= ($urandom_range(0, 1) != 0);
            2: rsp_chan.ready <= ($urandom_range(0, 7) != 0);
            default: rsp_chan.ready <= ((cyc % 5) < 2);
         endcase
      end
   end

   // Result checker.
   always @(posedge clock) begin
      weight_set_type w;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_weights.size() == 0) begin
            $error("unexpected result transaction");
            failures++;
         end else begin
            w = pending_weights.pop_front();
            if (rsp_chan.weight_now !== w.w_now) begin
               $error("weight_now: expected %0d, got %0d", w.w_now, rsp_chan.weight_now);
               failures++;
            end
            if (rsp_chan.weight_older !== w.w_older) begin
               $error("weight_older: expected %0d, got %0d", w.w_older, rsp_chan.weight_older);
               failures++;
            end
            if (rsp_chan.weight_oldest !== w.w_oldest) begin
               $error("weight_oldest: expected %0d, got %0d", w.w_oldest,
                      rsp_chan.weight_oldest);
               failures++;
            end
            if (rsp_chan.status !== w.status) begin
               $error("status: expected %0d, got %0d", w.status, rsp_chan.status);
               failures++;
            end
         end
      end
   end

   // Watchdog on cycles without any transaction.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      wait (stimulus_done);
      while (pending_weights.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/vsab3_pkg.sv
rtl/core/vsab3_req_if.sv
rtl/core/vsab3_rsp_if.sv
rtl/core/vsab3_mul.sv
rtl/core/vsab3_div_cell.sv
rtl/core/vsab3_div.sv
rtl/core/variable_step_ab3_coefficients.sv
rtl/core/vsab3_checker.sv
verif/variable_step_ab3_coefficients_tb.sv
